/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Concurrent checks in simulation; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/cpa_pkg.sv */
// Shared types and constants of the Coulomb potential accumulator.
// No dependencies.
package cpa_pkg;
	localparam int IN_W     = 32;
	localparam int ACC_W    = 48;
	localparam int ACC_FRAC = 24;
	localparam int S_W      = 66;
	localparam int D_W      = 33;
	localparam int N_W      = IN_W + ACC_FRAC;
	localparam int EXT_W    = N_W + 2;

	typedef struct packed {
		logic [IN_W-1:0] ax;
		logic [IN_W-1:0] ay;
		logic [IN_W-1:0] az;
		logic [IN_W-1:0] qmag;
		logic            qneg;
		logic            qpos;
		logic            first;
		logic            last;
	} item_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_st_t;
endpackage

/* hdl/cpa_front.sv */
// Front end: takes charge beats, forms |dx|,|dy|,|dz| and |q|, queues them.
// Depends on cpa_pkg.
module cpa_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           point_x,
	input  logic signed [31:0]           point_y,
	input  logic signed [31:0]           point_z,
	input  logic signed [31:0]           charge_x,
	input  logic signed [31:0]           charge_y,
	input  logic signed [31:0]           charge_z,
	input  logic signed [31:0]           charge_value,
	input  logic                         first_charge,
	input  logic                         last_charge,
	output logic                         q_valid,
	output cpa_pkg::item_t               q_item,
	input  logic                         q_pop
);
	import cpa_pkg::*;

	item_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	item_t       item_in;
	logic        push;
	logic signed [IN_W:0] dx, dy, dz;

	assign dx = {charge_x[31], charge_x} - {point_x[31], point_x};
	assign dy = {charge_y[31], charge_y} - {point_y[31], point_y};
	assign dz = {charge_z[31], charge_z} - {point_z[31], point_z};

	always_comb begin
		item_in.ax    = dx[IN_W] ? IN_W'(-dx) : dx[IN_W-1:0];
		item_in.ay    = dy[IN_W] ? IN_W'(-dy) : dy[IN_W-1:0];
		item_in.az    = dz[IN_W] ? IN_W'(-dz) : dz[IN_W-1:0];
		item_in.qmag  = charge_value[31] ? IN_W'(-charge_value) : charge_value;
		item_in.qneg  = charge_value[31];
		item_in.qpos  = !charge_value[31] && (charge_value != '0);
		item_in.first = first_charge;
		item_in.last  = last_charge;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

/* hdl/cpa_back.sv */
// Back end: squares, bit-serial square root and division, saturating sum.
// Depends on cpa_pkg.
module cpa_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cpa_pkg::item_t        q_item,
	output cpa_pkg::back_st_t     st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [47:0]    potential,
	output logic                  saturated,
	output logic                  zero_distance
);
	import cpa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [5:0] SQRT_LAST = 6'(D_W - 1);
	localparam logic [5:0] DIV_LAST  = 6'(N_W - 1);
	localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'((64'sd1 <<< (ACC_W-1)) - 1);
	localparam logic signed [EXT_W-1:0] ACC_MIN = -EXT_W'(64'sd1 <<< (ACC_W-1));

	logic [2:0]        state_q;
	logic [5:0]        cnt_q;
	item_t             it_q;
	logic [63:0]       prod_q;
	logic [S_W-1:0]    s_q;
	logic [D_W+2:0]    rem_q;
	logic [D_W-1:0]    root_q;
	logic [D_W-1:0]    drem_q;
	logic [N_W-1:0]    n_q, quo_q;
	logic              zero_q;
	logic signed [ACC_W-1:0] sum_q;
	logic              ovf_q, coin_q;
	logic              out_valid_q;
	logic signed [ACC_W-1:0] pot_q;
	logic              sat_q, zd_q;

	logic [IN_W-1:0]   mul_a;
	logic [S_W-1:0]    s_sum;
	logic [D_W+2:0]    rem_sh, trial;
	logic [D_W:0]      dsh;
	logic              pop, go;
	logic signed [ACC_W-1:0] base_sum;
	logic              base_ovf;
	logic signed [EXT_W-1:0] s_ext;
	logic signed [ACC_W-1:0] new_sum;
	logic              new_ovf, new_coin;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mul_a = it_q.ax;
			2'd1:    mul_a = it_q.ay;
			default: mul_a = it_q.az;
		endcase
	end

	assign s_sum  = s_q + {2'b00, prod_q};
	assign rem_sh = {rem_q[D_W:0], s_q[S_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign dsh    = {drem_q, n_q[N_W-1]};

	// accumulate step; first mark starts from a clean sum
	always_comb begin
		base_sum = it_q.first ? '0 : sum_q;
		base_ovf = it_q.first ? 1'b0 : ovf_q;
		new_coin = (it_q.first ? 1'b0 : coin_q) | zero_q;
		s_ext    = {{(EXT_W-ACC_W){base_sum[ACC_W-1]}}, base_sum};
		if (!zero_q) begin
			if (it_q.qpos) s_ext = s_ext - $signed({2'b00, quo_q});
			else if (it_q.qneg) s_ext = s_ext + $signed({2'b00, quo_q});
		end
		new_ovf = base_ovf;
		if (s_ext > ACC_MAX) begin
			new_sum = ACC_MAX[ACC_W-1:0];
			new_ovf = 1'b1;
		end else if (s_ext < ACC_MIN) begin
			new_sum = ACC_MIN[ACC_W-1:0];
			new_ovf = 1'b1;
		end else begin
			new_sum = s_ext[ACC_W-1:0];
		end
	end

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign go  = (state_q == ST_ACC) && (!it_q.last || !out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (pop) it_q <= q_item;
			ST_SQ: begin
				if (cnt_q != 6'd3) prod_q <= mul_a * mul_a;
				if (cnt_q == 6'd0) begin
					s_q    <= '0;
					zero_q <= 1'b0;
				end else if (cnt_q == 6'd3) begin
					s_q    <= s_sum;
					zero_q <= (s_sum == '0);
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					s_q <= s_sum;
				end
			end
			ST_SQRT: begin
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[D_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[D_W-2:0], 1'b0};
				end
				s_q <= s_q << 2;
				if (cnt_q == SQRT_LAST) begin
					n_q    <= {it_q.qmag, ACC_FRAC'(0)};
					drem_q <= '0;
				end
			end
			ST_DIV: begin
				if (dsh >= {1'b0, root_q}) begin
					drem_q <= D_W'(dsh - {1'b0, root_q});
					quo_q  <= {quo_q[N_W-2:0], 1'b1};
				end else begin
					drem_q <= dsh[D_W-1:0];
					quo_q  <= {quo_q[N_W-2:0], 1'b0};
				end
				n_q <= n_q << 1;
			end
			default: ;
		endcase
		if (go && it_q.last) begin
			pot_q <= new_sum;
			sat_q <= new_ovf;
			zd_q  <= new_coin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			coin_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (pop) begin
					state_q <= ST_SQ;
					cnt_q   <= '0;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= (s_sum == '0) ? ST_ACC : ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == SQRT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) state_q <= ST_ACC;
				end
				ST_ACC: if (go) begin
					sum_q   <= new_sum;
					ovf_q   <= new_ovf;
					coin_q  <= new_coin;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (go && it_q.last) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign st.pop        = pop;
	assign st.busy       = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign potential     = pot_q;
	assign saturated     = sat_q;
	assign zero_distance = zd_q;
endmodule

/* hdl/coulomb_potential_accumulator_top.sv */
// Coulomb potential accumulator: one charge per beat, a two-deep queue between
// the front end and a bit-serial back end. Each charge with a nonzero distance
// passes in the back end through the squares, the square root, the division, the
// sum and the fetch of the next charge, with the root and divide one bit a cycle;
// a coincident charge skips the root and divide. The front keeps accepting
// until two charges wait.
`include "assert_macros.svh"
module coulomb_potential_accumulator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  logic signed [31:0]  charge_x,
	input  logic signed [31:0]  charge_y,
	input  logic signed [31:0]  charge_z,
	input  logic signed [31:0]  charge_value,
	input  logic                first_charge,
	input  logic                last_charge,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [47:0]  potential,
	output logic                saturated,
	output logic                zero_distance
);
	import cpa_pkg::*;

	logic     q_valid;
	item_t    q_item;
	back_st_t st;

	cpa_front u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.point_x, .point_y, .point_z,
		.charge_x, .charge_y, .charge_z, .charge_value,
		.first_charge, .last_charge,
		.q_valid, .q_item, .q_pop(st.pop)
	);

	cpa_back u_back (
		.clk, .arst_n, .q_valid, .q_item, .st,
		.out_valid, .out_ready, .potential, .saturated, .zero_distance
	);

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, st.pop && !q_valid)
	`ASSERT_CLK(a_empty_ready, clk, arst_n, !q_valid |-> in_ready)
	`ASSERT_CLK(a_pop_busy, clk, arst_n, st.pop |=> st.busy)
endmodule

/* tb/tb.sv */
// Testbench for coulomb_potential_accumulator_top: directed and random charge runs,
// checked against a bit-exact potential predictor held in a scoreboard class.
// Depends on cpa_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb;
	import cpa_pkg::*;

	localparam longint ACC_HI = 64'sh00007FFFFFFFFFFF;
	localparam longint ACC_LO = -64'sh0000800000000000;
	localparam int LIMIT = 2000000;

	class potential_board;
		longint sum;
		bit ovf;
		bit coinc;
		logic [47:0] exp_pot[$];
		bit exp_sat[$];
		bit exp_zd[$];
		int errors;

		function new();
			sum = 0;
			ovf = 0;
			coinc = 0;
			errors = 0;
		endfunction

		// trial squares stay below 2^70, so the search runs at 72 bits
		function logic [67:0] root68(logic [67:0] s);
			logic [71:0] r, t;
			r = 0;
			for (int b = 34; b >= 0; b--) begin
				t = r | (72'd1 << b);
				if (t * t <= 72'(s)) r = t;
			end
			return r[67:0];
		endfunction

		function void note_charge(logic signed [31:0] px, py, pz, cx, cy, cz, qv,
				bit first, bit last);
			logic signed [33:0] dx, dy, dz;
			logic [67:0] s, d;
			logic [63:0] qm, mag;
			longint acc;
			dx = 34'(cx) - 34'(px);
			dy = 34'(cy) - 34'(py);
			dz = 34'(cz) - 34'(pz);
			if (first) begin
				sum = 0;
				ovf = 0;
				coinc = 0;
			end
			s = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
			if (s == 0) begin
				coinc = 1;
			end else begin
				d = root68(s);
				qm = qv < 0 ? 64'(-64'(qv)) : 64'(qv);
				mag = (qm << ACC_FRAC) / d[63:0];
				acc = qv > 0 ? sum - longint'(mag) : (qv < 0 ? sum + longint'(mag) : sum);
				if (acc > ACC_HI) begin
					acc = ACC_HI;
					ovf = 1;
				end else if (acc < ACC_LO) begin
					acc = ACC_LO;
					ovf = 1;
				end
				sum = acc;
			end
			if (last) begin
				exp_pot.push_back(sum[47:0]);
				exp_sat.push_back(ovf);
				exp_zd.push_back(coinc);
			end
		endfunction

		function void check_result(logic [47:0] pot, bit sat, bit zd);
			logic [47:0] ep;
			bit es, ez;
			if (exp_pot.size() == 0) begin
				$display("%0t: unexpected result pot=%h", $time, pot);
				errors++;
				return;
			end
			ep = exp_pot.pop_front();
			es = exp_sat.pop_front();
			ez = exp_zd.pop_front();
			if (pot !== ep) begin
				$display("%0t: potential expected %h actual %h", $time, ep, pot);
				errors++;
			end
			if (sat !== es) begin
				$display("%0t: saturated expected %b actual %b", $time, es, sat);
				errors++;
			end
			if (zd !== ez) begin
				$display("%0t: zero_distance expected %b actual %b", $time, ez, zd);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic signed [31:0] charge_x = 0, charge_y = 0, charge_z = 0, charge_value = 0;
	logic first_charge = 0, last_charge = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [47:0] potential;
	logic saturated, zero_distance;

	potential_board board = new();
	int cycles = 0;
	bit hold_rx = 0;

	coulomb_potential_accumulator_top dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			board.note_charge(point_x, point_y, point_z, charge_x, charge_y, charge_z,
				charge_value, first_charge, last_charge);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(potential, saturated, zero_distance);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, or a long hold-off while hold_rx is set
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_ready <= 0;
			end else begin
				g = gap_len();
				if (g > 0 && out_ready == 1) begin
					out_ready <= 0;
					repeat (g) @(negedge clk);
				end
				out_ready <= 1;
			end
		end
	end

	// returns at the falling edge after acceptance with valid still high;
	// the next beat replaces or drops it, or the caller drops it, in that same step
	task automatic send_beat(logic signed [31:0] px, py, pz, cx, cy, cz, qv,
			bit f, bit l);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		point_x <= px; point_y <= py; point_z <= pz;
		charge_x <= cx; charge_y <= cy; charge_z <= cz;
		charge_value <= qv;
		first_charge <= f; last_charge <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 3) - 2;
			2: return $urandom_range(0, 4095) - 2048;
			default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		endcase
	endfunction

	task automatic random_run(int len);
		logic signed [31:0] px, py, pz;
		int m;
		m = $urandom_range(0, 3);
		px = rand_word(m); py = rand_word(m); pz = rand_word(m);
		for (int i = 0; i < len; i++) begin
			int cm;
			bit f, l;
			logic signed [31:0] cx, cy, cz;
			cm = $urandom_range(0, 3);
			if ($urandom_range(0, 15) == 0) begin
				cx = px; cy = py; cz = pz;
			end else begin
				cx = rand_word(cm); cy = rand_word(cm); cz = rand_word(cm);
				if (cm == 1) begin
					cx = px + cx; cy = py + cy; cz = pz + cz;
				end
			end
			f = (i == 0);
			l = (i == len - 1);
			// occasional broken runs
			if ($urandom_range(0, 19) == 0) f = ~f;
			if ($urandom_range(0, 19) == 0) l = ~l;
			send_beat(px, py, pz, cx, cy, cz, rand_word($urandom_range(0, 3)), f, l);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (board.exp_pot.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: extremes, coincident, zero charge, saturation, missing first mark
		send_beat(0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 1, 1);
		send_beat(0, 0, 0, 1, 0, 0, 32'sh7FFFFFFF, 1, 1);
		send_beat(0, 0, 0, 0, 0, 1, 32'sh80000000, 1, 1);
		send_beat(0, 0, 0, 0, 1, 0, 0, 1, 1);
		send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1, 1);
		send_beat(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1, 1);
		for (int i = 0; i < 12; i++)
			send_beat(0, 0, 0, 1, 0, 0, 32'sh7FFFFFFF, i == 0, i == 11);
		for (int i = 0; i < 4; i++)
			send_beat(5, 5, 5, 5, 5, 5, 32'sh80000000, 0, i == 3);
		send_beat(-1, -1, -1, 0, 0, 0, 32'sh80000000, 0, 1);
		send_beat(0, 0, 0, 2, 2, 2, 1, 1, 0);
		send_beat(0, 0, 0, 2, 2, 2, -1, 0, 1);
		// sender pauses until everything has come back
		wait_drained();
		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_rx = 1;
				repeat (3000) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < 12; i++)
				send_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, 1, 1);
		join
		sent = 0;
		while (sent < 1800) begin
			int len;
			len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 8);
			random_run(len);
			sent += len;
		end
		wait_drained();
		if (board.errors == 0 && board.exp_pot.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
